// File: rtl/core/selective_repeat_receive_window_defines.svh
// ----------------------------------------------------------------------------
// selective repeat receive window assertion macros
// shared concurrent assertion forms for the receive window checkers
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH

// same-cycle implication, off during reset
`define SRRW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SRRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/srrw_pkg.sv
// ----------------------------------------------------------------------------
// srrw_pkg
// shared widths and limits of the selective repeat receive window
// ----------------------------------------------------------------------------
package srrw_pkg;

  // default parameter values
  localparam int SEQ_BITS_DEF = 8;
  localparam int TAG_BITS_DEF = 16;

  // fixed port field widths
  localparam int ADDR_W     = 32;
  localparam int SEQ_W      = 8;
  localparam int TAG_W      = 16;
  localparam int WIN_BITS   = 6;
  localparam int IN_DATA_W  = ADDR_W + SEQ_W + TAG_W;
  localparam int OUT_DATA_W = SEQ_W + TAG_W;
  localparam int OUT_USER_W = 2;

  // window limits
  localparam int MAX_WINDOW  = 32;
  localparam int MAX_RELEASE = 32;
  localparam int CNT_BITS    = $clog2(MAX_RELEASE + 1);
  localparam logic [WIN_BITS-1:0] WINDOW_RST = WIN_BITS'(8);

  // register map, word index taken from paddr[2]
  localparam logic REG_LOCAL_ADDRESS = 1'b0;
  localparam logic REG_WINDOW_SIZE   = 1'b1;

  // result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

endpackage

// File: rtl/core/selective_repeat_receive_window.sv
// Selective repeat receive window. One frame header is taken per beat on the
// s_ side; the block then holds s_tready low until the frame's last result
// beat has left on the m_ side. A frame for another address gives no beat.
// A frame that releases nothing gives only its acknowledgment beat. A frame
// that releases frames goes through one round per released frame (mark test
// and store read, read data load, output beat), set by the single read port
// of the tag store, plus one closing mark test before the acknowledgment; at
// most 32 frames are released per header. Output stalls hold the sequencer in
// its output state. The mark bits are flip-flops cleared by reset, so no
// clearing pass is needed.
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// receiver side of a selective repeat sliding window with in-order release
// ----------------------------------------------------------------------------
module selective_repeat_receive_window #(
  parameter int SEQ_BITS = srrw_pkg::SEQ_BITS_DEF,
  parameter int TAG_BITS = srrw_pkg::TAG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input frame headers
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // dest_address[31:0], seq_num[39:32], frame_tag[55:40]
  input  logic [srrw_pkg::IN_DATA_W-1:0]  s_tdata,
  // msg_end
  input  logic                            s_tlast,
  // results
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_seq[7:0], out_tag[23:8]
  output logic [srrw_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind[0], out_end[1]
  output logic [srrw_pkg::OUT_USER_W-1:0] m_tuser,
  // last
  output logic                            m_tlast,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import srrw_pkg::*;

  localparam int SEQ_DEPTH = 1 << SEQ_BITS;
  localparam int CMP_BITS  = ((SEQ_BITS > WIN_BITS) ? SEQ_BITS : WIN_BITS) + 1;
  localparam int ST_W      = TAG_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_LOAD,
    S_OUT,
    S_ACK
  } state_t;

  state_t               state;
  logic [ADDR_W-1:0]    local_address;
  logic [WIN_BITS-1:0]  window_size;
  logic [ADDR_W-1:0]    in_dest;
  logic [SEQ_BITS-1:0]  in_seq;
  logic [TAG_BITS-1:0]  in_tag;
  logic                 in_eom;
  logic [SEQ_BITS-1:0]  next_exp;
  logic [SEQ_BITS-1:0]  idx;
  logic [CNT_BITS-1:0]  rel_cnt;
  logic [SEQ_DEPTH-1:0] mark;

  logic                 cfg_wr;
  logic [WIN_BITS-1:0]  win_eff;
  logic [SEQ_BITS-1:0]  seq_dist;
  logic                 addr_hit;
  logic                 in_win;
  logic                 store_wr;
  logic                 rel_more;
  logic [SEQ_BITS-1:0]  idx_inc;
  logic [ST_W-1:0]      st_wdata;
  logic [ST_W-1:0]      st_rdata;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= '0;
      window_size   <= WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LOCAL_ADDRESS: local_address <= pwdata;
        REG_WINDOW_SIZE:   window_size   <= pwdata[WIN_BITS-1:0];
        default:           local_address <= local_address;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LOCAL_ADDRESS: prdata = local_address;
      REG_WINDOW_SIZE:   prdata = 32'(window_size);
      default:           prdata = '0;
    endcase
  end

  // shared sequence unit: distance from next expected and window test
  assign win_eff  = (window_size > WIN_BITS'(MAX_WINDOW)) ? WIN_BITS'(MAX_WINDOW)
                                                          : window_size;
  assign seq_dist = in_seq - next_exp;
  assign in_win   = CMP_BITS'(seq_dist) < CMP_BITS'(win_eff);
  assign addr_hit = (in_dest == local_address);
  assign store_wr = (state == S_CHECK) && addr_hit && in_win;
  assign rel_more = mark[idx] && (rel_cnt != CNT_BITS'(MAX_RELEASE));
  assign idx_inc  = idx + SEQ_BITS'(1);

  assign s_tready = (state == S_IDLE);

  // tag and end flag store
  assign st_wdata = {in_eom, in_tag};

  srrw_ram #(
    .WIDTH (ST_W),
    .DEPTH (SEQ_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (in_seq),
    .wr_data (st_wdata),
    .rd_en   (state == S_READ),
    .rd_addr (idx),
    .rd_data (st_rdata)
  );

  // arrival marks
  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= '0;
    end else if (store_wr) begin
      mark[in_seq] <= 1'b1;
    end else if (state == S_OUT && m_tready) begin
      mark[idx] <= 1'b0;
    end
  end

  // sequencer and result beat registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      next_exp <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_dest <= s_tdata[ADDR_W-1:0];
            in_seq  <= s_tdata[ADDR_W +: SEQ_BITS];
            in_tag  <= TAG_BITS'(s_tdata[ADDR_W+SEQ_W +: TAG_W]);
            in_eom  <= s_tlast;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx     <= in_seq;
          rel_cnt <= '0;
          if (!addr_hit) begin
            state <= S_IDLE;
          end else if (in_win && seq_dist == '0) begin
            state <= S_READ;
          end else begin
            m_tvalid <= 1'b1;
            m_tdata  <= {TAG_W'(0), SEQ_W'(in_seq)};
            m_tuser  <= {1'b0, KIND_ACK};
            m_tlast  <= 1'b1;
            state    <= S_ACK;
          end
        end
        S_READ: begin
          if (rel_more) begin
            state <= S_LOAD;
          end else begin
            m_tvalid <= 1'b1;
            m_tdata  <= {TAG_W'(0), SEQ_W'(in_seq)};
            m_tuser  <= {1'b0, KIND_ACK};
            m_tlast  <= 1'b1;
            state    <= S_ACK;
          end
        end
        S_LOAD: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {TAG_W'(st_rdata[TAG_BITS-1:0]), SEQ_W'(idx)};
          m_tuser  <= {st_rdata[TAG_BITS], KIND_DELIVER};
          m_tlast  <= 1'b0;
          state    <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            idx      <= idx_inc;
            next_exp <= idx_inc;
            rel_cnt  <= rel_cnt + CNT_BITS'(1);
            state    <= S_READ;
          end
        end
        S_ACK: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/srrw_ram.sv
// ----------------------------------------------------------------------------
// srrw_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module srrw_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/srrw_checker.sv
// ----------------------------------------------------------------------------
// srrw_checker
// port level checks of the selective repeat receive window
// ----------------------------------------------------------------------------
`include "selective_repeat_receive_window_defines.svh"

module srrw_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [srrw_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [srrw_pkg::OUT_USER_W-1:0] m_tuser,
  input logic                            m_tlast
);
  import srrw_pkg::*;

  // a stalled result beat holds
  `SRRW_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
    "result beat changed while stalled")

  // one frame at a time: no new header while results are pending
  `SRRW_ASSERT_NOW(a_one_frame, clk, rst, m_tvalid, !s_tready,
    "input ready while a result beat is pending")

  // a taken header closes the input on the next cycle
  `SRRW_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready,
    "input still ready right after a header beat")

  // acknowledgment is the final beat and carries no tag or end flag
  `SRRW_ASSERT_NOW(a_ack_form, clk, rst, m_tvalid && m_tuser[0] == KIND_ACK,
    m_tlast && m_tdata[OUT_DATA_W-1:SEQ_W] == '0 && !m_tuser[1],
    "malformed acknowledgment beat")

  // a delivered frame never closes the result run
  `SRRW_ASSERT_NOW(a_deliver_not_last, clk, rst,
    m_tvalid && m_tuser[0] == KIND_DELIVER, !m_tlast,
    "delivered frame beat marked last")

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (.*);

// File: sim/srrw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srrw_scoreboard
// watches the frame, result and register channels of the receive window,
// keeps its own copy of the window state, and compares every result beat
// against the oldest outstanding expectation, field by field
// ----------------------------------------------------------------------------
module srrw_scoreboard (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // dest_address[31:0], seq_num[39:32], frame_tag[55:40]
  input  logic [srrw_pkg::IN_DATA_W-1:0]  s_tdata,
  // msg_end
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // out_seq[7:0], out_tag[23:8]
  input  logic [srrw_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind[0], out_end[1]
  input  logic [srrw_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  input  logic [31:0]                     prdata,
  input  logic                            pready,
  output int                              failures,
  output int                              pending,
  output logic [srrw_pkg::SEQ_W-1:0]      window_base
);
  import srrw_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
    logic             eom;
    logic             last;
  } rx_result_t;

  // mirrored registers and window state
  logic [ADDR_W-1:0]   own_addr;
  logic [WIN_BITS-1:0] win_reg;
  logic [SEQ_W-1:0]    next_seq;
  logic                arrived [256];
  logic [TAG_W-1:0]    held_tag [256];
  logic                held_eom [256];
  rx_result_t          owed_results [$];

  // one accepted frame header: store, release in order, then acknowledge
  task automatic accept_frame(input logic [ADDR_W-1:0] dest, input logic [SEQ_W-1:0] seq,
                              input logic eom, input logic [TAG_W-1:0] tag);
    int               win;
    int               n;
    logic [SEQ_W-1:0] seq_off;
    logic [SEQ_W-1:0] idx;
    if (dest != own_addr) return;
    win = (win_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_reg);
    seq_off = seq - next_seq;
    if (int'(seq_off) < win) begin
      arrived[seq] = 1'b1;
      held_tag[seq] = tag;
      held_eom[seq] = eom;
      if (seq == next_seq) begin
        idx = seq;
        n = 0;
        while (n < MAX_RELEASE && arrived[idx]) begin
          owed_results.push_back('{KIND_DELIVER, idx, held_tag[idx], held_eom[idx], 1'b0});
          arrived[idx] = 1'b0;
          idx = idx + SEQ_W'(1);
          next_seq = idx;
          n++;
        end
      end
    end
    owed_results.push_back('{KIND_ACK, seq, '0, 1'b0, 1'b1});
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    rx_result_t want;
    if (rst) begin
      own_addr = '0;
      win_reg = WINDOW_RST;
      next_seq = '0;
      foreach (arrived[i]) arrived[i] = 1'b0;
      owed_results.delete();
      failures = 0;
    end else begin
      // register writes and read-back
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_WINDOW_SIZE) win_reg = pwdata[WIN_BITS-1:0];
          else own_addr = pwdata;
        end else if (paddr[2] == REG_WINDOW_SIZE) begin
          check_field("prdata window_size", 32'(win_reg), prdata);
        end else begin
          check_field("prdata local_address", own_addr, prdata);
        end
      end
      // result beat against the oldest expectation
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          $error("result beat with nothing expected: seq 0x%0h kind %0d",
                 m_tdata[7:0], m_tuser[0]);
          failures++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(m_tuser[0]));
          check_field("out_seq", 32'(want.seq), 32'(m_tdata[7:0]));
          check_field("out_tag", 32'(want.tag), 32'(m_tdata[23:8]));
          check_field("out_end", 32'(want.eom), 32'(m_tuser[1]));
          check_field("last", 32'(want.last), 32'(m_tlast));
        end
      end
      // frame header beat
      if (s_tvalid && s_tready)
        accept_frame(s_tdata[31:0], s_tdata[39:32], s_tlast, s_tdata[55:40]);
    end
    pending = owed_results.size();
    window_base = next_seq;
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives frame headers, output stalls and register writes into the selective
// repeat receive window; a checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb;
  import srrw_pkg::*;

  localparam logic [2:0] ADDR_LOCAL  = {REG_LOCAL_ADDRESS, 2'b00};
  localparam logic [2:0] ADDR_WINDOW = {REG_WINDOW_SIZE, 2'b00};
  localparam int PHASE_FRAMES = 28;

  typedef enum int {BLK_RANDOM, BLK_FULL_BURST, BLK_LEAVE_MARKS} block_kind_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    failures;
  int                    pending;
  logic [SEQ_W-1:0]      window_base;

  // stimulus-side view of the configuration
  logic [ADDR_W-1:0] own_addr_tb;
  int                win_eff;
  int                frames_sent;
  logic              calm;

  selective_repeat_receive_window dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  srrw_scoreboard watch (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .failures, .pending, .window_base
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // one header beat, with an occasional idle burst ahead of it
  task automatic send_frame(input logic [ADDR_W-1:0] dest, input logic [SEQ_W-1:0] seq,
                            input logic eom, input logic [TAG_W-1:0] tag);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {tag, seq, dest};
    s_tlast = eom;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (dest == own_addr_tb) frames_sent++;
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // wait until every expected beat is out, plus slack for dropped frames
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_phase(input logic [ADDR_W-1:0] addr, input logic [WIN_BITS-1:0] win);
    drain();
    apb_access(1'b1, ADDR_LOCAL, addr);
    apb_access(1'b1, ADDR_WINDOW, {{(32-WIN_BITS){1'b0}}, win});
    apb_access(1'b0, ADDR_LOCAL, '0);
    apb_access(1'b0, ADDR_WINDOW, '0);
    own_addr_tb = addr;
    win_eff = (win > MAX_WINDOW) ? MAX_WINDOW : int'(win);
  endtask

  // a group of frames shaped around the current window base
  task automatic run_block(input block_kind_t blk);
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] offs [32];
    logic [SEQ_W-1:0] tmp;
    int               k;
    int               j;
    int               t;
    int               mode;
    @(negedge clk);
    s_tvalid = 1'b0;
    base = window_base;
    mode = $urandom_range(0, 9);
    if (blk == BLK_FULL_BURST) begin
      // fill the whole window backwards so the last frame releases all of it
      for (j = 0; j < MAX_WINDOW; j++)
        send_frame(own_addr_tb, base + 8'(MAX_WINDOW - 1 - j), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
    end else if (blk == BLK_LEAVE_MARKS) begin
      // marks beyond the base that stay set across a window change
      send_frame(own_addr_tb, base + 8'(win_eff - 1), 1'b1, 16'($urandom_range(0, 65535)));
      send_frame(own_addr_tb, base + 8'(win_eff / 2), 1'b0, 16'($urandom_range(0, 65535)));
    end else if (mode <= 3) begin
      // window fill in shuffled order, with duplicates now and then
      k = (win_eff == 0) ? 1 : $urandom_range(1, win_eff);
      for (j = 0; j < k; j++) offs[j] = 8'(j);
      for (j = k - 1; j > 0; j--) begin
        t = $urandom_range(0, j);
        tmp = offs[j];
        offs[j] = offs[t];
        offs[t] = tmp;
      end
      if ($urandom_range(0, 1) == 1) begin
        for (j = 0; j < k; j++)
          if (offs[j] == 0) t = j;
        offs[t] = offs[k-1];
        offs[k-1] = '0;
      end
      for (j = 0; j < k; j++) begin
        send_frame(own_addr_tb, base + offs[j], 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 7) == 0)
          send_frame(own_addr_tb, base + offs[j], 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 65535)));
      end
    end else if (mode <= 6) begin
      // in-order run
      k = $urandom_range(1, 8);
      for (j = 0; j < k; j++)
        send_frame(own_addr_tb, base + 8'(j), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
    end else if (mode == 7) begin
      // frames outside the window
      k = $urandom_range(1, 3);
      for (j = 0; j < k; j++)
        send_frame(own_addr_tb, base + 8'(win_eff) + 8'($urandom_range(0, 255 - win_eff)),
                   1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    end else begin
      // noise: random numbers, half of them for other addresses
      k = $urandom_range(1, 4);
      for (j = 0; j < k; j++)
        send_frame(($urandom_range(0, 1) == 1) ? own_addr_tb : ADDR_W'($urandom()),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic run_phase();
    int target;
    target = frames_sent + PHASE_FRAMES;
    while (frames_sent < target) run_block(BLK_RANDOM);
  endtask

  // result side stalls in random bursts
  initial begin
    int len;
    m_tready = 1'b0;
    forever begin
      if (calm) begin
        m_tready = 1'b1;
        @(negedge clk);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
        m_tready = 1'b1;
        repeat (len) @(negedge clk);
        len = $urandom_range(1, 12);
        m_tready = 1'b0;
        repeat (len) @(negedge clk);
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    frames_sent = 0;
    own_addr_tb = '0;
    win_eff = int'(WINDOW_RST);
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed frames under the reset configuration
    send_frame(32'hFFFF_FFFF, 8'd0, 1'b1, 16'h1234);
    send_frame(32'h0, 8'd0, 1'b1, 16'hFFFF);
    send_frame(32'h0, 8'd2, 1'b0, 16'h0000);
    send_frame(32'h0, 8'd1, 1'b1, 16'hA5A5);
    send_frame(32'h0, 8'd10, 1'b1, 16'h5A5A);
    send_frame(32'h0, 8'd11, 1'b0, 16'hFFFF);
    send_frame(32'h0, 8'd4, 1'b0, 16'h1111);
    send_frame(32'h0, 8'd4, 1'b1, 16'h2222);
    send_frame(32'h0, 8'd3, 1'b0, 16'h0000);
    send_frame(32'h0, 8'd255, 1'b1, 16'hFFFF);
    send_frame(32'h0, 8'd0, 1'b0, 16'h8001);
    for (int s = 5; s <= 9; s++)
      send_frame(32'h0, 8'(s), 1'(s & 1), 16'(s * 16'h0F0F));

    // widest window: full release burst, then marks left behind
    set_phase(32'hFFFF_FFFF, 6'd32);
    run_block(BLK_FULL_BURST);
    run_phase();
    run_block(BLK_LEAVE_MARKS);

    // zero window: acknowledgments only, stale marks kept
    set_phase($urandom(), 6'd0);
    run_phase();

    // window above the limit acts as the limit
    set_phase(32'h0, 6'd63);
    run_phase();

    set_phase($urandom(), 6'd1);
    run_phase();

    set_phase($urandom(), 6'd33);
    run_phase();

    set_phase($urandom(), 6'($urandom_range(2, 31)));
    run_phase();

    // last stretch without idling on either side
    set_phase($urandom(), 6'd32);
    calm = 1'b1;
    run_phase();

    drain();
    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
